// File: rtl/assert_macros.svh
// assertion helpers, all clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, ante, cons)

`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/tcs_pkg.sv
package tcs_pkg;

    localparam int COUNT_WIDTH  = 32;
    localparam int FIELD_WIDTH  = 32;
    localparam int NUM_COUNTERS = 10;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // byte watched by each counter, in result order
    localparam logic [7:0] WATCHED_BYTES [NUM_COUNTERS] = '{
        8'h0A,  // lf
        8'h2C,  // comma
        8'h2D,  // dash
        8'h3A,  // colon
        8'h5B,  // open bracket
        8'h7B,  // open brace
        8'h22,  // double quote
        8'h27,  // single quote
        8'h7C,  // pipe
        8'h26   // ampersand
    };

    localparam logic [7:0] BYTE_TAB       = 8'h09;
    localparam logic [7:0] BYTE_LF        = 8'h0A;
    localparam logic [7:0] BYTE_CR        = 8'h0D;
    localparam logic [7:0] BYTE_DEL       = 8'h7F;
    localparam logic [7:0] BYTE_PRINT_MIN = 8'h20;

    typedef logic [NUM_COUNTERS-1:0][COUNT_WIDTH-1:0] tcs_cnt_t;

    typedef struct packed {
        logic [NUM_COUNTERS-1:0] hit;
        logic                    high;
        logic                    bad;
        logic                    last;
    } tcs_class_t;

    function automatic logic is_bad_printable(input logic [7:0] b);
        logic bad;
        bad = 1'b0;
        if (b == BYTE_DEL)
        begin
            bad = 1'b1;
        end
        else if (b < BYTE_PRINT_MIN)
        begin
            bad = !(b == BYTE_TAB || b == BYTE_LF || b == BYTE_CR);
        end
        return bad;
    endfunction

endpackage

// File: rtl/tcs_classify.sv
module tcs_classify
    import tcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic       in_valid,
    input  logic [7:0] text_byte,
    input  logic       last_byte,
    output logic       cls_valid,
    output tcs_class_t cls
);

    logic       cls_valid_reg;
    tcs_class_t cls_reg;
    tcs_class_t cls_next;

    always_comb
    begin
        for (int k = 0; k < NUM_COUNTERS; k++)
        begin
            cls_next.hit[k] = (text_byte == WATCHED_BYTES[k]);
        end
        cls_next.high = text_byte[7];
        cls_next.bad  = is_bad_printable(text_byte);
        cls_next.last = last_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            cls_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cls_reg <= cls_next;
        end
    end

    assign cls_valid = cls_valid_reg;
    assign cls       = cls_reg;

endmodule

// File: rtl/text_character_statistics.sv
// path: the request carrying last_byte is registered in the classify stage and then in the result register
// throughput: one byte per cycle; the whole pipe holds only while a result is stalled
// reset: asynchronous, active low; clears the running counts, the running flags and both valid stages
// a result is produced only for a last byte, after which all counts and flags restart at zero
module text_character_statistics
    import tcs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             text_byte,
    input  logic                   last_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [FIELD_WIDTH-1:0] newline_count,
    output logic [FIELD_WIDTH-1:0] comma_count,
    output logic [FIELD_WIDTH-1:0] dash_count,
    output logic [FIELD_WIDTH-1:0] colon_count,
    output logic [FIELD_WIDTH-1:0] bracket_count,
    output logic [FIELD_WIDTH-1:0] brace_count,
    output logic [FIELD_WIDTH-1:0] double_quote_count,
    output logic [FIELD_WIDTH-1:0] single_quote_count,
    output logic [FIELD_WIDTH-1:0] pipe_count,
    output logic [FIELD_WIDTH-1:0] ampersand_count,
    output logic                   saw_non_ascii,
    output logic                   saw_bad_printable
);

`include "assert_macros.svh"

    logic       advance;
    logic       s1_valid;
    tcs_class_t s1_cls;

    tcs_cnt_t cnt_reg;
    tcs_cnt_t cnt_next;
    tcs_cnt_t cnt_upd;
    logic     high_reg;
    logic     high_next;
    logic     high_upd;
    logic     bad_reg;
    logic     bad_next;
    logic     bad_upd;
    logic     emit;

    logic                                    res_valid_reg;
    logic [NUM_COUNTERS-1:0][FIELD_WIDTH-1:0] res_cnt_reg;
    logic                                    res_high_reg;
    logic                                    res_bad_reg;

    // the pipe moves unless a finished result is waiting
    assign advance  = !(res_valid_reg && out_stall);
    assign in_stall = !advance;

    tcs_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_valid),
        .text_byte (text_byte),
        .last_byte (last_byte),
        .cls_valid (s1_valid),
        .cls       (s1_cls)
    );

    assign emit = advance && s1_valid && s1_cls.last;

    always_comb
    begin
        for (int k = 0; k < NUM_COUNTERS; k++)
        begin
            cnt_upd[k] = cnt_reg[k];
            if (s1_cls.hit[k] && cnt_reg[k] != COUNT_MAX)
            begin
                cnt_upd[k] = cnt_reg[k] + COUNT_WIDTH'(1);
            end
        end
        high_upd = high_reg | s1_cls.high;
        bad_upd  = bad_reg | s1_cls.bad;

        cnt_next  = cnt_reg;
        high_next = high_reg;
        bad_next  = bad_reg;
        if (advance && s1_valid)
        begin
            if (s1_cls.last)
            begin
                cnt_next  = '0;
                high_next = 1'b0;
                bad_next  = 1'b0;
            end
            else
            begin
                cnt_next  = cnt_upd;
                high_next = high_upd;
                bad_next  = bad_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            high_reg      <= 1'b0;
            bad_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            high_reg <= high_next;
            bad_reg  <= bad_next;
            if (advance)
            begin
                res_valid_reg <= s1_valid && s1_cls.last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            for (int k = 0; k < NUM_COUNTERS; k++)
            begin
                res_cnt_reg[k] <= FIELD_WIDTH'(cnt_upd[k]);
            end
            res_high_reg <= high_upd;
            res_bad_reg  <= bad_upd;
        end
    end

    assign out_valid          = res_valid_reg;
    assign newline_count      = res_cnt_reg[0];
    assign comma_count        = res_cnt_reg[1];
    assign dash_count         = res_cnt_reg[2];
    assign colon_count        = res_cnt_reg[3];
    assign bracket_count      = res_cnt_reg[4];
    assign brace_count        = res_cnt_reg[5];
    assign double_quote_count = res_cnt_reg[6];
    assign single_quote_count = res_cnt_reg[7];
    assign pipe_count         = res_cnt_reg[8];
    assign ampersand_count    = res_cnt_reg[9];
    assign saw_non_ascii      = res_high_reg;
    assign saw_bad_printable  = res_bad_reg;

    `ASSERT_NEXT(counts_clear_after_last, emit, cnt_reg == '0 && !high_reg && !bad_reg)
    `ASSERT_NEXT(newline_count_no_drop, !emit, cnt_reg[0] >= $past(cnt_reg[0]))
    `ASSERT_NEXT(high_flag_sticky, high_reg && !emit, high_reg)
    `ASSERT_IMPLIES(result_only_from_last, emit, s1_cls.last && s1_valid && advance)

endmodule
